[design/psishp_pkg.sv]
`timescale 1ns / 1ps

package psishp_pkg;

   // Parser phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SKIP,
      PH_HEADER,
      PH_DONE
   } phase_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TRUNC = 2'd1,
      ST_ZERO  = 2'd2,
      ST_STUFF = 2'd3
   } status_type;

   localparam int unsigned HDR_BYTES     = 8;
   localparam int unsigned HDR_IDX_W     = $clog2(HDR_BYTES);
   localparam int unsigned RSP_DATA_W    = 80;

   localparam logic [7:0]  STUFFING_TID  = 8'h72;
   localparam logic [11:0] EXT_HDR_BYTES = 12'd9;

   // Header byte positions
   localparam logic [HDR_IDX_W-1:0] IDX_SHORT_END = HDR_IDX_W'(2);
   localparam logic [HDR_IDX_W-1:0] IDX_EXT_END   = HDR_IDX_W'(7);

   // One result, fields in tdata order
   typedef struct packed {
      logic [3:0]  pad;
      status_type  status;
      logic [11:0] body_length;
      logic [7:0]  last_section_num;
      logic [7:0]  section_num;
      logic        current_next;
      logic [4:0]  version;
      logic [15:0] stream_id;
      logic [11:0] sect_len;
      logic [1:0]  reserved_bits;
      logic        private_flag;
      logic        syntax_flag;
      logic [7:0]  tid_byte;
   } result_type;

endpackage

[design/psi_section_header_parser_core.sv]
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents
// req_      in   8      tdata: data_byte; tuser: first_byte; tlast: last_in_packet
// rsp_      out  80     tdata: packed header fields and status (see port list)
//
// One payload byte per clock; a byte is taken every cycle the result register
// is empty or being emptied. The result appears in the cycle after the byte that
// completes (or truncates) the header. Parsing state is a small phase machine,
// a skip counter and eight header byte registers.
// Synchronous active-high reset returns the parser to idle; bytes are ignored
// until a transfer flagged as first byte. A stalled result holds req_tready low.
module psi_section_header_parser_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] data_byte
   input  logic                          req_tuser,  // [0] first_byte
   input  logic                          req_tlast,  // last_in_packet
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] table identifier, [8] syntax_flag, [9] private_flag, [11:10] reserved_bits,
   // [23:12] section length, [39:24] stream_id, [44:40] version,
   // [45] current_next, [53:46] section_num, [61:54] last_section_num,
   // [73:62] body_length, [75:74] status, [79:76] zero
   output logic [psishp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import psishp_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [7:0]             skip_ff, skip_in;
   logic [HDR_IDX_W-1:0]   idx_ff, idx_in;
   logic [7:0]             hdr_ff [HDR_BYTES];
   logic [7:0]             hb     [HDR_BYTES];
   logic                   rsp_valid_ff;
   result_type             rsp_data_ff, res;
   logic                   accept, emit;
   status_type             status;
   logic [11:0]            sec_len;
   logic                   hdr_wr;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Header bytes as they stand after this byte; cleared view on a first byte
   assign hdr_wr = !req_tuser && (phase_ff == PH_HEADER);
   always_comb begin
      for (int i = 0; i < HDR_BYTES; i++) begin
         if (req_tuser) begin
            hb[i] = 8'h00;
         end else if (hdr_wr && (idx_ff == HDR_IDX_W'(i))) begin
            hb[i] = req_tdata;
         end else begin
            hb[i] = hdr_ff[i];
         end
      end
   end

   assign sec_len = {hb[1][3:0], hb[2]};

   // Next phase and result decision
   always_comb begin
      phase_in = phase_ff;
      emit     = 1'b0;
      status   = ST_OK;
      if (req_tuser) begin
         phase_in = (req_tdata != 8'h00) ? PH_SKIP : PH_HEADER;
         if (req_tlast) begin
            emit   = 1'b1;
            status = ST_TRUNC;
         end
      end else begin
         case (phase_ff)
            PH_SKIP: begin
               if (skip_ff == 8'd1) begin
                  phase_in = PH_HEADER;
               end
               if (req_tlast) begin
                  emit   = 1'b1;
                  status = ST_TRUNC;
               end
            end
            PH_HEADER: begin
               if (idx_ff == IDX_SHORT_END && sec_len == 12'd0) begin
                  emit   = 1'b1;
                  status = ST_ZERO;
               end else if (idx_ff == IDX_SHORT_END && hb[0] == STUFFING_TID) begin
                  emit   = 1'b1;
                  status = ST_STUFF;
               end else if (idx_ff == IDX_SHORT_END && !hb[1][7]) begin
                  emit   = 1'b1;
                  status = ST_OK;
               end else if (idx_ff == IDX_EXT_END) begin
                  emit   = 1'b1;
                  status = ST_OK;
               end else if (req_tlast) begin
                  emit   = 1'b1;
                  status = ST_TRUNC;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
      if (emit) begin
         phase_in = PH_DONE;
      end
   end

   // Counters and result fields
   always_comb begin
      skip_in = skip_ff;
      idx_in  = idx_ff;
      if (req_tuser) begin
         skip_in = req_tdata;
         idx_in  = '0;
      end else if (phase_ff == PH_SKIP) begin
         skip_in = skip_ff - 8'd1;
      end else if (phase_ff == PH_HEADER) begin
         idx_in = idx_ff + HDR_IDX_W'(1);
      end

      res               = '0;
      res.tid_byte      = hb[0];
      res.syntax_flag   = hb[1][7];
      res.private_flag  = hb[1][6];
      res.reserved_bits = hb[1][5:4];
      res.sect_len      = sec_len;
      res.status        = status;
      if (status == ST_OK) begin
         if (hb[1][7]) begin
            res.stream_id        = {hb[3], hb[4]};
            res.version          = hb[5][5:1];
            res.current_next     = hb[5][0];
            res.section_num      = hb[6];
            res.last_section_num = hb[7];
            res.body_length      = (sec_len > EXT_HDR_BYTES) ? sec_len - EXT_HDR_BYTES
                                                              : 12'd0;
         end else begin
            res.body_length = sec_len;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         skip_ff      <= 8'd0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            skip_ff  <= skip_in;
            idx_ff   <= idx_in;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Header bytes and result register
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_ff[i] <= hb[i];
         end
         if (emit) begin
            rsp_data_ff <= res;
         end
      end
   end

endmodule
